>>> rtl/core/ajhc_pkg.sv
// ----------------------------------------------------------------------------
// ajhc_pkg
// Shared widths, register indexes, types and helpers for the axis conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package ajhc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int AW          = SAMPLE_BITS + 2;
    localparam int MAG_W       = SAMPLE_BITS + 1;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int OUT_W       = SAMPLE_BITS + 1;
    localparam int CNT_W       = $clog2(SAMPLE_BITS);
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_JITTER_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER_MARGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_ENABLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_LEFT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_CENTER    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_RIGHT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_DEADBAND  = 3'd6;

    localparam logic [1:0] HOLD_LIMIT = 2'd3;

    typedef logic [SAMPLE_BITS-1:0]     sample_t;
    typedef logic signed [AW-1:0]       wide_t;
    typedef logic [MAG_W-1:0]           mag_t;
    typedef logic [PROD_W-1:0]          prod_t;
    typedef logic signed [OUT_W-1:0]    out_t;

    localparam sample_t SAMPLE_MAX   = '1;
    localparam sample_t CENTER_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic done;
        logic saturated;
    } div_status_t;

    function automatic mag_t abs_mag(input wide_t x);
        wide_t a;
        a = x[AW-1] ? -x : x;
        return a[MAG_W-1:0];
    endfunction

    function automatic wide_t widen(input sample_t x);
        return $signed({2'b00, x});
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/axis_jitter_hold_and_center_calibration.sv
// ----------------------------------------------------------------------------
// axis_jitter_hold_and_center_calibration
// Conditions one joystick axis: anti-jitter hold, then center dead band,
// clamping and side-matched scaling to a signed offset.
//
// Usage: a raw sample enters on the in_valid/in_ready channel and one signed
// axis_value leaves on the out_valid/out_ready channel for every sample.
// Configuration registers are written on the cfg channel by index; cfg_ready
// is always high, and writes are expected only while the block is idle.
// Each transaction passes from input acceptance to out_valid through clamping, setup,
// multiply, divider start, the bit-serial divider iterations and hand-off.
// A saturated quotient or a zero divisor skips the divider iterations.
// One sample is in flight at a time and the input reopens the cycle after the result
// is loaded, so a new sample waits until the previous one has been handed off.
// The result sits in an output register, so the next sample is accepted while
// the previous result waits; when the receiver stalls, a finished result waits
// in the last stage until the output register frees up.
// Reset clears the chosen position and hold count and restores register
// defaults: both stages disabled, center at mid range, limits at full range.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_jitter_hold_and_center_calibration (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire ajhc_pkg::sample_t                 raw_sample,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output ajhc_pkg::out_t                         axis_value,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ajhc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire ajhc_pkg::sample_t                 cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CAL    = 3'd1;
    localparam logic [2:0] S_PREP   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DSTART = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]             state_reg, state_next;

    logic                   jitter_enable_reg;
    ajhc_pkg::sample_t      jitter_margin_reg;
    logic                   cal_enable_reg;
    ajhc_pkg::sample_t      cal_left_reg;
    ajhc_pkg::sample_t      cal_center_reg;
    ajhc_pkg::sample_t      cal_right_reg;
    ajhc_pkg::sample_t      cal_deadband_reg;

    ajhc_pkg::sample_t      chosen_reg, chosen_next;
    logic [1:0]             hold_reg, hold_next;

    ajhc_pkg::sample_t      val_reg, val_next;
    ajhc_pkg::sample_t      vc_reg, vc_next;
    ajhc_pkg::wide_t        lo_reg, lo_next;
    ajhc_pkg::wide_t        hi_reg, hi_next;
    ajhc_pkg::wide_t        wl_reg, wl_next;
    ajhc_pkg::wide_t        wr_reg, wr_next;
    logic                   band_reg, band_next;
    logic                   low_reg, low_next;

    ajhc_pkg::mag_t         abs_t_reg, abs_t_next;
    ajhc_pkg::mag_t         abs_num_reg, abs_num_next;
    ajhc_pkg::mag_t         abs_den_reg, abs_den_next;
    logic                   sign_reg, sign_next;
    ajhc_pkg::prod_t        prod_reg, prod_next;
    ajhc_pkg::out_t         res_reg, res_next;

    logic                   out_valid_reg, out_valid_next;
    ajhc_pkg::out_t         axis_value_reg;

    logic [ajhc_pkg::SAMPLE_BITS:0] p_plus_m;
    logic [ajhc_pkg::SAMPLE_BITS:0] x_plus_m;
    logic                   jump;
    logic                   in_fire;
    logic                   out_load;

    ajhc_pkg::wide_t        v_w;
    ajhc_pkg::wide_t        vc_w;
    ajhc_pkg::wide_t        t_w;
    ajhc_pkg::wide_t        num_w;
    ajhc_pkg::wide_t        den_w;
    logic                   scale;
    logic                   negate;
    ajhc_pkg::sample_t      mag;

    logic                   div_start;
    ajhc_pkg::sample_t      div_quotient;
    ajhc_pkg::div_status_t  div_status;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign div_start = (state_reg == S_DSTART);
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    ajhc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (abs_den_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jitter_enable_reg <= 1'b0;
            jitter_margin_reg <= '0;
            cal_enable_reg    <= 1'b0;
            cal_left_reg      <= '0;
            cal_center_reg    <= ajhc_pkg::CENTER_RESET;
            cal_right_reg     <= ajhc_pkg::SAMPLE_MAX;
            cal_deadband_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ajhc_pkg::CFG_JITTER_ENABLE: jitter_enable_reg <= cfg_data[0];
                ajhc_pkg::CFG_JITTER_MARGIN: jitter_margin_reg <= cfg_data;
                ajhc_pkg::CFG_CAL_ENABLE:    cal_enable_reg    <= cfg_data[0];
                ajhc_pkg::CFG_CAL_LEFT:      cal_left_reg      <= cfg_data;
                ajhc_pkg::CFG_CAL_CENTER:    cal_center_reg    <= cfg_data;
                ajhc_pkg::CFG_CAL_RIGHT:     cal_right_reg     <= cfg_data;
                ajhc_pkg::CFG_CAL_DEADBAND:  cal_deadband_reg  <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        p_plus_m = {1'b0, chosen_reg} + {1'b0, jitter_margin_reg};
        x_plus_m = {1'b0, raw_sample} + {1'b0, jitter_margin_reg};
        if (raw_sample > chosen_reg)
        begin
            jump = {1'b0, raw_sample} > p_plus_m;
        end
        else
        begin
            jump = x_plus_m < {1'b0, chosen_reg};
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        chosen_next  = chosen_reg;
        hold_next    = hold_reg;
        val_next     = val_reg;
        vc_next      = vc_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        wl_next      = wl_reg;
        wr_next      = wr_reg;
        band_next    = band_reg;
        low_next     = low_reg;
        abs_t_next   = abs_t_reg;
        abs_num_next = abs_num_reg;
        abs_den_next = abs_den_reg;
        sign_next    = sign_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        v_w          = ajhc_pkg::widen(val_reg);
        vc_w         = ajhc_pkg::widen(vc_reg);
        t_w          = '0;
        num_w        = '0;
        den_w        = '0;
        scale        = 1'b0;
        negate       = 1'b0;
        mag          = div_status.saturated ? ajhc_pkg::SAMPLE_MAX : div_quotient;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    val_next = raw_sample;
                    if (jitter_enable_reg)
                    begin
                        if (jump)
                        begin
                            chosen_next = raw_sample;
                        end
                        else if (hold_reg < ajhc_pkg::HOLD_LIMIT)
                        begin
                            hold_next = hold_reg + 2'd1;
                            val_next  = chosen_reg;
                        end
                        else
                        begin
                            hold_next   = '0;
                            chosen_next = raw_sample;
                        end
                    end
                    state_next = S_CAL;
                end
            end
            S_CAL:
            begin
                lo_next   = ajhc_pkg::widen(cal_center_reg) - ajhc_pkg::widen(cal_deadband_reg);
                hi_next   = ajhc_pkg::widen(cal_center_reg) + ajhc_pkg::widen(cal_deadband_reg);
                band_next = (val_reg == '0) || ((v_w >= lo_next) && (v_w <= hi_next));
                if (val_reg < cal_left_reg)
                begin
                    vc_next = cal_left_reg;
                end
                else if (val_reg > cal_right_reg)
                begin
                    vc_next = cal_right_reg;
                end
                else
                begin
                    vc_next = val_reg;
                end
                low_next   = vc_next < cal_center_reg;
                wl_next    = lo_next - ajhc_pkg::widen(cal_left_reg);
                wr_next    = ajhc_pkg::widen(cal_right_reg) - hi_next;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                if (!cal_enable_reg)
                begin
                    t_w = v_w;
                end
                else if (band_reg)
                begin
                    t_w = '0;
                end
                else if (low_reg)
                begin
                    t_w    = lo_reg - vc_w;
                    negate = 1'b1;
                    scale  = wl_reg > wr_reg;
                    num_w  = wr_reg;
                    den_w  = wl_reg;
                end
                else
                begin
                    t_w   = vc_w - hi_reg;
                    scale = wr_reg > wl_reg;
                    num_w = wl_reg;
                    den_w = wr_reg;
                end
                abs_t_next = ajhc_pkg::abs_mag(t_w);
                if (scale)
                begin
                    abs_num_next = ajhc_pkg::abs_mag(num_w);
                    abs_den_next = ajhc_pkg::abs_mag(den_w);
                    sign_next    = t_w[ajhc_pkg::AW-1] ^ negate
                                   ^ num_w[ajhc_pkg::AW-1] ^ den_w[ajhc_pkg::AW-1];
                end
                else
                begin
                    abs_num_next = ajhc_pkg::mag_t'(1);
                    abs_den_next = ajhc_pkg::mag_t'(1);
                    sign_next    = t_w[ajhc_pkg::AW-1] ^ negate;
                end
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = ajhc_pkg::prod_t'(abs_t_reg) * ajhc_pkg::prod_t'(abs_num_reg);
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    res_next   = sign_reg ? -ajhc_pkg::out_t'({1'b0, mag})
                                          : ajhc_pkg::out_t'({1'b0, mag});
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chosen_reg    <= '0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chosen_reg    <= chosen_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        vc_reg      <= vc_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        wl_reg      <= wl_next;
        wr_reg      <= wr_next;
        band_reg    <= band_next;
        low_reg     <= low_next;
        abs_t_reg   <= abs_t_next;
        abs_num_reg <= abs_num_next;
        abs_den_reg <= abs_den_next;
        sign_reg    <= sign_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
        if (out_load)
        begin
            axis_value_reg <= res_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign axis_value = axis_value_reg;

    a_hold_idle_when_disabled: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_fire && !jitter_enable_reg) |=> ($stable(hold_reg) && $stable(chosen_reg))
    ) else $error("hold state changed while the jitter stage is disabled");

    a_no_min_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (axis_value != {1'b1, {(ajhc_pkg::OUT_W-1){1'b0}}})
    ) else $error("axis value escaped saturation range");

    a_sat_full_scale: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_status.done && div_status.saturated)
        |=> (res_reg == ajhc_pkg::out_t'({1'b0, ajhc_pkg::SAMPLE_MAX})
             || res_reg == -ajhc_pkg::out_t'({1'b0, ajhc_pkg::SAMPLE_MAX}))
    ) else $error("saturated quotient did not give a full-scale result");

endmodule

`default_nettype wire

>>> rtl/core/ajhc_divider.sv
// ----------------------------------------------------------------------------
// ajhc_divider
// Bit-serial restoring divider that flags quotients beyond the full sample range as saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module ajhc_divider (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire ajhc_pkg::prod_t        dividend,
    input  wire ajhc_pkg::mag_t         divisor,
    output ajhc_pkg::sample_t           quotient,
    output ajhc_pkg::div_status_t       status
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic                                sat_reg, sat_next;
    logic [ajhc_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic [ajhc_pkg::MAG_W:0]            rem_reg, rem_next;
    ajhc_pkg::sample_t                   quo_reg, quo_next;
    ajhc_pkg::mag_t                      den_reg, den_next;

    logic [ajhc_pkg::MAG_W:0]            upper;
    logic [ajhc_pkg::MAG_W:0]            trial;
    logic                                qbit;

    always_comb
    begin
        upper     = dividend[ajhc_pkg::PROD_W-1:ajhc_pkg::SAMPLE_BITS];
        trial     = {rem_reg[ajhc_pkg::MAG_W-1:0], quo_reg[ajhc_pkg::SAMPLE_BITS-1]};
        qbit      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            den_next = divisor;
            cnt_next = '0;
            rem_next = upper;
            if (divisor == '0)
            begin
                sat_next  = 1'b0;
                quo_next  = '0;
                done_next = 1'b1;
            end
            else if (upper >= {1'b0, divisor})
            begin
                sat_next  = 1'b1;
                quo_next  = '0;
                done_next = 1'b1;
            end
            else
            begin
                sat_next  = 1'b0;
                quo_next  = dividend[ajhc_pkg::SAMPLE_BITS-1:0];
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? (trial - {1'b0, den_reg}) : trial;
            quo_next = {quo_reg[ajhc_pkg::SAMPLE_BITS-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ajhc_pkg::CNT_W'(ajhc_pkg::SAMPLE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient         = quo_reg;
    assign status.done      = done_reg;
    assign status.saturated = sat_reg;

endmodule

`default_nettype wire

>>> verif/axis_jitter_hold_and_center_calibration_tb.sv
// ----------------------------------------------------------------------------
// axis_jitter_hold_and_center_calibration_tb
// Drives raw axis samples through the conditioner under many register
// settings, with random gaps on the input and random stalls on the output.
// A scoreboard predicts every axis value from its own copy of the hold state
// and the registers, and compares each result transaction in order.
// ----------------------------------------------------------------------------
module axis_jitter_hold_and_center_calibration_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ajhc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam longint OUT_LIMIT    = 65535;
    localparam int     PHASES       = 12;
    localparam int     PHASE_ITEMS  = 102;
    localparam int     DRAIN_CYCLES = 30;
    localparam int     IDLE_PCT     = 27;

    class axis_scoreboard;
        logic              jit_en;
        ajhc_pkg::sample_t margin;
        logic              cal_en;
        ajhc_pkg::sample_t left;
        ajhc_pkg::sample_t center;
        ajhc_pkg::sample_t right;
        ajhc_pkg::sample_t deadband;
        ajhc_pkg::sample_t chosen;
        logic [1:0]        hold;
        ajhc_pkg::out_t    pending_values[$];
        int                errors;
        int                samples_seen;
        int                results_checked;
        int                held_outputs;
        int                deadband_zeros;
        int                saturations;

        function new();
            jit_en          = 1'b0;
            margin          = '0;
            cal_en          = 1'b0;
            left            = '0;
            center          = ajhc_pkg::CENTER_RESET;
            right           = ajhc_pkg::SAMPLE_MAX;
            deadband        = '0;
            chosen          = '0;
            hold            = '0;
            errors          = 0;
            samples_seen    = 0;
            results_checked = 0;
            held_outputs    = 0;
            deadband_zeros  = 0;
            saturations     = 0;
        endfunction

        function void set_reg(logic [ajhc_pkg::CFG_IDX_W-1:0] idx, ajhc_pkg::sample_t d);
            case (idx)
                ajhc_pkg::CFG_JITTER_ENABLE: jit_en   = d[0];
                ajhc_pkg::CFG_JITTER_MARGIN: margin   = d;
                ajhc_pkg::CFG_CAL_ENABLE:    cal_en   = d[0];
                ajhc_pkg::CFG_CAL_LEFT:      left     = d;
                ajhc_pkg::CFG_CAL_CENTER:    center   = d;
                ajhc_pkg::CFG_CAL_RIGHT:     right    = d;
                ajhc_pkg::CFG_CAL_DEADBAND:  deadband = d;
                default: ;
            endcase
        endfunction

        function longint scaled(longint v, longint num, longint den);
            if (den == 0)
                return 0;
            return (v * num) / den;
        endfunction

        function ajhc_pkg::out_t conditioned_value(ajhc_pkg::sample_t s);
            longint v;
            longint p;
            longint c;
            longint lo;
            longint hi;
            longint wl;
            longint wr;
            logic   jump;
            v = longint'(s);
            if (jit_en)
            begin
                p = longint'(chosen);
                if (v > p)
                    jump = v > p + longint'(margin);
                else
                    jump = v < p - longint'(margin);
                if (jump)
                    chosen = s;
                else if (hold < ajhc_pkg::HOLD_LIMIT)
                begin
                    hold = hold + 2'd1;
                    v = p;
                    held_outputs++;
                end
                else
                begin
                    hold = '0;
                    chosen = s;
                end
            end
            if (cal_en)
            begin
                c  = longint'(center);
                lo = c - longint'(deadband);
                hi = c + longint'(deadband);
                if (v == 0 || (v >= lo && v <= hi))
                begin
                    v = 0;
                    deadband_zeros++;
                end
                else
                begin
                    if (v < longint'(left))
                        v = longint'(left);
                    else if (v > longint'(right))
                        v = longint'(right);
                    wl = lo - longint'(left);
                    wr = longint'(right) - hi;
                    if (v < c)
                    begin
                        v = lo - v;
                        if (wl > wr)
                            v = scaled(v, wr, wl);
                        v = -v;
                    end
                    else
                    begin
                        v = v - hi;
                        if (wr > wl)
                            v = scaled(v, wl, wr);
                    end
                end
            end
            if (v > OUT_LIMIT || v < -OUT_LIMIT)
                saturations++;
            if (v > OUT_LIMIT)
                v = OUT_LIMIT;
            else if (v < -OUT_LIMIT)
                v = -OUT_LIMIT;
            return ajhc_pkg::out_t'(v);
        endfunction

        function void note_sample(ajhc_pkg::sample_t s);
            samples_seen++;
            pending_values.push_back(conditioned_value(s));
        endfunction

        function void check_result(ajhc_pkg::out_t got);
            ajhc_pkg::out_t want;
            results_checked++;
            if (pending_values.size() == 0)
            begin
                errors++;
                $display("%0t: axis_value expected none, actual %0d", $time, got);
            end
            else
            begin
                want = pending_values.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: axis_value expected %0d, actual %0d", $time, want, got);
                end
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    ajhc_pkg::sample_t              raw_sample;
    logic                           out_valid;
    logic                           out_ready;
    ajhc_pkg::out_t                 axis_value;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ajhc_pkg::CFG_IDX_W-1:0] cfg_index;
    ajhc_pkg::sample_t              cfg_data;

    axis_scoreboard sb = new();
    logic              quiet;
    int                rx_hold;
    int                last_raw;
    int                settings;
    ajhc_pkg::sample_t burst[$];

    axis_jitter_hold_and_center_calibration i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_sample (raw_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .axis_value (axis_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(axis_value);
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready = 1'b0;
            rx_hold--;
        end
        else
        begin
            out_ready = quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_sample(input ajhc_pkg::sample_t s);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        raw_sample = s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_sample(s);
        @(negedge clk);
    endtask

    task automatic play_burst();
        foreach (burst[k])
            send_sample(burst[k]);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.pending_values.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [ajhc_pkg::CFG_IDX_W-1:0] idx,
                             input ajhc_pkg::sample_t d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, d);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input ajhc_pkg::sample_t jen, input ajhc_pkg::sample_t jm,
                             input ajhc_pkg::sample_t cen, input ajhc_pkg::sample_t lt,
                             input ajhc_pkg::sample_t ct, input ajhc_pkg::sample_t rt,
                             input ajhc_pkg::sample_t db);
        wait_idle();
        write_reg(ajhc_pkg::CFG_JITTER_ENABLE, jen);
        write_reg(ajhc_pkg::CFG_JITTER_MARGIN, jm);
        write_reg(ajhc_pkg::CFG_CAL_ENABLE, cen);
        write_reg(ajhc_pkg::CFG_CAL_LEFT, lt);
        write_reg(ajhc_pkg::CFG_CAL_CENTER, ct);
        write_reg(ajhc_pkg::CFG_CAL_RIGHT, rt);
        write_reg(ajhc_pkg::CFG_CAL_DEADBAND, db);
        if ($urandom_range(1))
            write_reg(CFG_UNUSED, ajhc_pkg::sample_t'($urandom_range(65535)));
        settings++;
    endtask

    task automatic random_setting(input int ph);
        int                c;
        int                lim;
        int                n;
        ajhc_pkg::sample_t jen;
        ajhc_pkg::sample_t jm;
        ajhc_pkg::sample_t cen;
        jen = (ajhc_pkg::sample_t'($urandom_range(65535)) & 16'hFFFE)
              | ajhc_pkg::sample_t'(ph % 3 != 2);
        cen = (ajhc_pkg::sample_t'($urandom_range(65535)) & 16'hFFFE)
              | ajhc_pkg::sample_t'(ph % 4 != 1);
        case ($urandom_range(3))
            0:       jm = '0;
            1:       jm = ajhc_pkg::SAMPLE_MAX;
            default: jm = ajhc_pkg::sample_t'($urandom_range(300));
        endcase
        if (ph == 0)
            write_all(16'hFFFF, ajhc_pkg::SAMPLE_MAX, 16'hFFFF, ajhc_pkg::SAMPLE_MAX,
                      ajhc_pkg::SAMPLE_MAX, ajhc_pkg::SAMPLE_MAX, ajhc_pkg::SAMPLE_MAX);
        else if (ph == 1)
            write_all(16'h0001, '0, 16'h0001, '0, '0, '0, '0);
        else if (ph < 4)
            write_all(jen, jm, cen, ajhc_pkg::sample_t'($urandom_range(65535)),
                      ajhc_pkg::sample_t'($urandom_range(65535)),
                      ajhc_pkg::sample_t'($urandom_range(65535)),
                      ajhc_pkg::sample_t'($urandom_range(65535)));
        else
        begin
            c   = $urandom_range(65535);
            lim = (c < 65535 - c) ? c : 65535 - c;
            n   = ($urandom_range(3) == 0) ? lim : $urandom_range(lim / 8);
            write_all(jen, jm, cen, ajhc_pkg::sample_t'($urandom_range(c - n)),
                      ajhc_pkg::sample_t'(c),
                      ajhc_pkg::sample_t'($urandom_range(65535, c + n)),
                      ajhc_pkg::sample_t'(n));
        end
    endtask

    function automatic ajhc_pkg::sample_t next_raw();
        int v;
        int span;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = 65535;
            2, 3:    v = $urandom_range(65535);
            4, 5, 6, 7:
            begin
                span = int'(sb.margin) + 2;
                v = last_raw + int'($urandom_range(2 * span)) - span;
            end
            default:
            begin
                span = int'(sb.deadband) + 4;
                v = int'(sb.center) + int'($urandom_range(2 * span)) - span;
            end
        endcase
        if (v < 0)
            v = 0;
        else if (v > 65535)
            v = 65535;
        last_raw = v;
        return ajhc_pkg::sample_t'(v);
    endfunction

    initial
    begin
        #5ms;
        $display("Timeout with %0d results still pending.", sb.pending_values.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        raw_sample = '0;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        quiet      = 1'b0;
        rx_hold    = 0;
        last_raw   = 0;
        settings   = 1;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        burst = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
        play_burst();

        // Writes to an unused index and to the upper bits of an enable are dropped.
        wait_idle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(ajhc_pkg::CFG_JITTER_ENABLE, 16'hFFFE);
        send_sample(16'h1234);

        // Jump, three holds, then the small move is taken and the count clears.
        write_all(16'h0001, 16'd16, 16'h0000, '0, ajhc_pkg::CENTER_RESET,
                  ajhc_pkg::SAMPLE_MAX, '0);
        burst = '{16'd1000, 16'd1005, 16'd1003, 16'd1010, 16'd1008, 16'd990, 16'hFFFF,
                  16'h0000};
        play_burst();

        write_all(16'h0000, '0, 16'h0001, 16'd1000, ajhc_pkg::CENTER_RESET, 16'd60000,
                  16'd500);
        burst = '{16'd0, 16'd32768, 16'd32268, 16'd32267, 16'd500, 16'hFFFF, 16'd40000};
        play_burst();

        // Misordered limits: saturation on both sides, then a zero divisor.
        write_all(16'h0000, '0, 16'h0001, 16'd3, 16'd65535, 16'd0, 16'd65533);
        send_sample(16'd1);
        write_all(16'h0000, '0, 16'h0001, 16'd65535, 16'd0, 16'd65533, 16'd65534);
        send_sample(16'd65535);
        write_all(16'h0000, '0, 16'h0001, 16'd100, 16'd100, 16'd50, 16'd0);
        send_sample(16'd200);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            random_setting(ph);
            quiet = (ph == 5);
            if (ph == 7)
                rx_hold = 400;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_sample(next_raw());
        end
        quiet = 1'b0;

        wait_idle();
        if (sb.pending_values.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.pending_values.size());
        end
        $display("Run covered %0d samples and %0d results over %0d register settings.",
                 sb.samples_seen, sb.results_checked, settings);
        $display("Held outputs %0d, dead band zeros %0d, saturated values %0d.",
                 sb.held_outputs, sb.deadband_zeros, sb.saturations);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ajhc_pkg.sv
rtl/core/ajhc_divider.sv
rtl/core/axis_jitter_hold_and_center_calibration.sv
verif/axis_jitter_hold_and_center_calibration_tb.sv
